>>> hw/rtl/qpsk_pkg.sv
package qpsk_pkg;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;
    localparam t_cfg_index CFG_PHASE_STEP       = 2'd0;
    localparam t_cfg_index CFG_SAMPLES_PER_BAUD = 2'd1;

    // symbol codes, one per reference phase
    typedef logic [1:0] t_symbol;
    localparam t_symbol SYM_REF1 = 2'd0;
    localparam t_symbol SYM_REF2 = 2'd1;
    localparam t_symbol SYM_REF3 = 2'd2;
    localparam t_symbol SYM_REF4 = 2'd3;

    localparam int NUM_REFS    = 4;
    localparam int METRIC_BITS = 64;
    localparam int QUEUE_DEPTH = 4;

    // sine pipeline depth in cycles
    localparam int SINE_LATENCY = 7;

    // odd polynomial for sin(pi/2 * x), q30 coefficients, highest order first
    localparam logic signed [31:0] POLY_COEF [5] = '{
        32'sd172272,
        -32'sd5026995,
        32'sd85569306,
        -32'sd693598669,
        32'sd1686629713
    };

endpackage

>>> hw/rtl/qpsk_in_if.sv
interface qpsk_in_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

>>> hw/rtl/qpsk_out_if.sv
interface qpsk_out_if
    import qpsk_pkg::*;
;
    logic    valid;
    logic    ready;
    t_symbol symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

>>> hw/rtl/qpsk_symbol_demodulator.sv
// throughput: one sample per cycle unless a decided symbol waits on a stalled output;
// the sine polynomial pipeline sets the depth; a four-entry queue lets input keep flowing
// while a symbol waits at the output; reset (synchronous, active low) clears phase, baud
// count, metrics, registers, the queue and all pipeline valid flags
module qpsk_symbol_demodulator
    import qpsk_pkg::*;
#(
    parameter int PHASE_BITS     = 16,
    parameter int SINE_FRAC_BITS = 15,
    parameter int SAMPLE_BITS    = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    qpsk_in_if.sink                  i_in,
    qpsk_out_if.source               o_out,
    input  logic                     i_cfg_we,
    input  t_cfg_index               i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int ENTRY_BITS = SAMPLE_BITS + PHASE_BITS + 1;

    logic                          q_push;
    logic                          q_full;
    logic                          q_pop;
    logic                          q_valid;
    logic signed [SAMPLE_BITS-1:0] f_sample;
    logic [PHASE_BITS-1:0]         f_phase;
    logic                          f_decide;
    logic [ENTRY_BITS-1:0]         q_wdata;
    logic [ENTRY_BITS-1:0]         q_rdata;
    logic signed [SAMPLE_BITS-1:0] b_sample;
    logic [PHASE_BITS-1:0]         b_phase;
    logic                          b_decide;

    // front: accept, phase and baud bookkeeping
    qpsk_front #(
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_sample    (f_sample),
        .o_phase     (f_phase),
        .o_decide    (f_decide)
    );

    assign q_wdata = {f_decide, f_phase, f_sample};

    qpsk_queue #(
        .WIDTH (ENTRY_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign b_sample = q_rdata[SAMPLE_BITS-1:0];
    assign b_phase  = q_rdata[SAMPLE_BITS +: PHASE_BITS];
    assign b_decide = q_rdata[ENTRY_BITS-1];

    // back: sines, metrics and decision
    qpsk_back #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_FRAC_BITS (SINE_FRAC_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_sample (b_sample),
        .i_q_phase  (b_phase),
        .i_q_decide (b_decide),
        .o_q_pop    (q_pop),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_symbol   (o_out.symbol)
    );

`ifndef SYNTH
    // the front never pushes into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    // the back never pops an empty queue
    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
`endif

endmodule

>>> hw/rtl/qpsk_front.sv
module qpsk_front
    import qpsk_pkg::*;
#(
    parameter int PHASE_BITS  = 16,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  t_cfg_index                    i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data,
    qpsk_in_if.sink                       s_in,
    input  logic                          i_q_full,
    output logic                          o_push,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic [PHASE_BITS-1:0]         o_phase,
    output logic                          o_decide
);

    logic [CFG_DATA_BITS-1:0] r_phase_step;
    logic [CFG_DATA_BITS-1:0] r_spb;
    logic [CFG_DATA_BITS-1:0] r_count;
    logic [PHASE_BITS-1:0]    r_phase;

    logic [PHASE_BITS+CFG_DATA_BITS-1:0] step_wide;
    logic [PHASE_BITS-1:0]               step;
    logic [CFG_DATA_BITS-1:0]            reload;
    logic                                accept;
    logic                                decide;

    // step trimmed or widened to the accumulator
    assign step_wide = (PHASE_BITS + CFG_DATA_BITS)'(r_phase_step);
    assign step      = step_wide[PHASE_BITS-1:0];

    // baud decision and count reload
    assign decide = (r_count == '0) || s_in.last_sample;
    assign reload = (r_spb != '0) ? r_spb - CFG_DATA_BITS'(1) : '0;

    // handshake into the queue
    assign s_in.ready = !i_q_full;
    assign accept     = s_in.valid && !i_q_full;
    assign o_push     = accept;
    assign o_sample   = s_in.sample;
    assign o_phase    = r_phase;
    assign o_decide   = decide;

    // configuration, phase and baud state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_spb        <= '0;
            r_count      <= '0;
            r_phase      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PHASE_STEP: begin
                        r_phase_step <= i_cfg_data;
                    end
                    CFG_SAMPLES_PER_BAUD: begin
                        r_spb   <= i_cfg_data;
                        r_count <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_phase <= r_phase - step;
                r_count <= decide ? reload : r_count - CFG_DATA_BITS'(1);
            end
        end
    end

endmodule

>>> hw/rtl/qpsk_queue.sv
module qpsk_queue
    import qpsk_pkg::*;
#(
    parameter int WIDTH = 49
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr;
    logic [PTR_BITS-1:0] r_rd;
    logic [CNT_BITS-1:0] r_count;

    function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] ptr);
        return (ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_BITS'(1);
    endfunction

    assign o_full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
    end

endmodule

>>> hw/rtl/qpsk_sine.sv
module qpsk_sine
    import qpsk_pkg::*;
#(
    parameter int PHASE_BITS     = 16,
    parameter int SINE_FRAC_BITS = 15
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [PHASE_BITS-1:0]            i_phase,
    output logic signed [SINE_FRAC_BITS+1:0] o_sine
);

    localparam int XB       = 17;
    localparam int RB       = PHASE_BITS - 2;
    localparam int EXT_BITS = RB + 18;
    localparam int MAG_BITS = SINE_FRAC_BITS + 1;
    localparam logic [XB-1:0] X_ONE     = XB'(65536);
    localparam logic [30:0]   V_MAX     = 31'(1) << 30;
    localparam logic [30:0]   ROUND_BIT = 31'(1) << (29 - SINE_FRAC_BITS);

    // one horner step: c + floor(a * x2 / 2^16)
    function automatic logic signed [31:0] horner(input logic signed [31:0] a,
                                                  input logic [XB-1:0] x2,
                                                  input logic signed [31:0] c);
        logic signed [49:0] prod;
        prod = a * $signed({1'b0, x2});
        return 32'(c + (prod >>> 16));
    endfunction

    logic [XB-1:0]        r_x   [6];
    logic                 r_neg [6];
    logic [XB-1:0]        r_sq  [4];
    logic signed [31:0]   r_acc [4];
    logic signed [MAG_BITS:0] r_sine;

    logic [1:0]            quad;
    logic [EXT_BITS-1:0]   phase_ext;
    logic [15:0]           x_raw;
    logic [XB-1:0]         x_in;
    logic [2*XB-1:0]       sq_full;
    logic signed [49:0]    v_prod;
    logic signed [33:0]    v;
    logic [30:0]           v_clamp;
    logic [30:0]           v_round;
    logic [MAG_BITS-1:0]   mag;

    // fold the phase to a quarter turn, q16 fraction
    assign quad      = i_phase[PHASE_BITS-1 -: 2];
    assign phase_ext = {i_phase[RB-1:0], 18'b0};
    assign x_raw     = phase_ext[PHASE_BITS +: 16];
    assign x_in      = quad[0] ? X_ONE - {1'b0, x_raw} : {1'b0, x_raw};

    assign sq_full = r_x[0] * r_x[0];

    // final product, clamp and rounding
    always_comb begin
        v_prod = r_acc[3] * $signed({1'b0, r_x[5]});
        v      = 34'(v_prod >>> 16);
        if (v < 0) begin
            v_clamp = '0;
        end else if (v > $signed({3'b0, V_MAX})) begin
            v_clamp = V_MAX;
        end else begin
            v_clamp = v[30:0];
        end
        v_round = v_clamp + ROUND_BIT;
        mag     = v_round[30 -: MAG_BITS];
    end

    // pipeline stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= x_in;
            r_neg[0] <= quad[1];
            for (int k = 1; k < 6; k++) begin
                r_x[k]   <= r_x[k-1];
                r_neg[k] <= r_neg[k-1];
            end
            r_sq[0] <= sq_full[XB+15:16];
            for (int k = 1; k < 4; k++) begin
                r_sq[k] <= r_sq[k-1];
            end
            r_acc[0] <= horner(POLY_COEF[0], r_sq[0], POLY_COEF[1]);
            for (int k = 1; k < 4; k++) begin
                r_acc[k] <= horner(r_acc[k-1], r_sq[k], POLY_COEF[k+1]);
            end
            r_sine <= r_neg[5] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    assign o_sine = r_sine;

endmodule

>>> hw/rtl/qpsk_back.sv
module qpsk_back
    import qpsk_pkg::*;
#(
    parameter int PHASE_BITS     = 16,
    parameter int SINE_FRAC_BITS = 15,
    parameter int SAMPLE_BITS    = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_q_sample,
    input  logic [PHASE_BITS-1:0]         i_q_phase,
    input  logic                          i_q_decide,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output t_symbol                       o_symbol
);

    localparam int SINE_BITS   = SINE_FRAC_BITS + 2;
    localparam int SCALED_BITS = SAMPLE_BITS + SINE_FRAC_BITS;
    localparam int DIFF_BITS   = SCALED_BITS + 1;
    localparam int ABS_BITS    = SCALED_BITS;
    localparam logic [PHASE_BITS-1:0] EIGHTH_1 = PHASE_BITS'(1) << (PHASE_BITS - 3);
    localparam logic [PHASE_BITS-1:0] EIGHTH_3 = PHASE_BITS'(3) << (PHASE_BITS - 3);

    function automatic logic [ABS_BITS-1:0] distance(input logic signed [SCALED_BITS-1:0] s,
                                                     input logic signed [SINE_BITS-1:0] w);
        logic signed [DIFF_BITS-1:0] d;
        d = DIFF_BITS'(s) - DIFF_BITS'(w);
        return d[DIFF_BITS-1] ? ABS_BITS'(-d) : ABS_BITS'(d);
    endfunction

    logic                          adv;
    logic [PHASE_BITS-1:0]         phase_a;
    logic [PHASE_BITS-1:0]         phase_b;
    logic signed [SINE_BITS-1:0]   sine_a;
    logic signed [SINE_BITS-1:0]   sine_b;
    logic signed [SINE_BITS-1:0]   ref_sine [NUM_REFS];
    logic signed [SCALED_BITS-1:0] scaled;

    logic [SINE_LATENCY-1:0]       r_tap_valid;
    logic [SINE_LATENCY-1:0]       r_tap_decide;
    logic signed [SAMPLE_BITS-1:0] r_tap_sample [SINE_LATENCY];

    logic                          r_v_dist;
    logic                          r_dec_dist;
    logic [ABS_BITS-1:0]           r_dist [NUM_REFS];

    logic [METRIC_BITS-1:0]        r_sum  [NUM_REFS];
    logic [METRIC_BITS-1:0]        n_sum  [NUM_REFS];
    logic [METRIC_BITS:0]          sum_wide [NUM_REFS];
    logic                          r_v_cand;
    logic [METRIC_BITS-1:0]        r_cand [NUM_REFS];

    logic                          r_v_pair;
    t_symbol                       r_pair_id  [2];
    logic [METRIC_BITS-1:0]        r_pair_min [2];

    logic                          r_out_valid;
    t_symbol                       r_symbol;

    // whole back end moves unless a decided symbol meets a full output register
    assign adv     = !(r_v_pair && r_out_valid && !i_ready);
    assign o_q_pop = adv && i_q_valid;

    // references two and one sit an eighth and three eighths ahead
    assign phase_a = i_q_phase + EIGHTH_1;
    assign phase_b = i_q_phase + EIGHTH_3;

    qpsk_sine #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_FRAC_BITS (SINE_FRAC_BITS)
    ) u_sine_a (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_phase (phase_a),
        .o_sine  (sine_a)
    );

    qpsk_sine #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_FRAC_BITS (SINE_FRAC_BITS)
    ) u_sine_b (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_phase (phase_b),
        .o_sine  (sine_b)
    );

    // the other two references are half a turn on, so just negated
    assign ref_sine[0] = sine_b;
    assign ref_sine[1] = sine_a;
    assign ref_sine[2] = -sine_a;
    assign ref_sine[3] = -sine_b;

    assign scaled = {r_tap_sample[SINE_LATENCY-1], {SINE_FRAC_BITS{1'b0}}};

    // item taps alongside the sine pipeline
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tap_sample[0] <= i_q_sample;
            r_tap_decide[0] <= i_q_decide;
            for (int k = 1; k < SINE_LATENCY; k++) begin
                r_tap_sample[k] <= r_tap_sample[k-1];
                r_tap_decide[k] <= r_tap_decide[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_valid <= '0;
        end else if (adv) begin
            r_tap_valid <= {r_tap_valid[SINE_LATENCY-2:0], i_q_valid};
        end
    end

    // distances to the four references
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_dist <= 1'b0;
        end else if (adv) begin
            r_v_dist <= r_tap_valid[SINE_LATENCY-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dec_dist <= r_tap_decide[SINE_LATENCY-1];
            for (int k = 0; k < NUM_REFS; k++) begin
                r_dist[k] <= distance(scaled, ref_sine[k]);
            end
        end
    end

    // saturating metric update
    always_comb begin
        for (int k = 0; k < NUM_REFS; k++) begin
            sum_wide[k] = {1'b0, r_sum[k]} + (METRIC_BITS + 1)'(r_dist[k]);
            n_sum[k]    = sum_wide[k][METRIC_BITS] ? '1 : sum_wide[k][METRIC_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_cand <= 1'b0;
            for (int k = 0; k < NUM_REFS; k++) begin
                r_sum[k] <= '0;
            end
        end else if (adv) begin
            r_v_cand <= r_v_dist && r_dec_dist;
            if (r_v_dist) begin
                for (int k = 0; k < NUM_REFS; k++) begin
                    r_sum[k] <= r_dec_dist ? '0 : n_sum[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_v_dist && r_dec_dist) begin
            for (int k = 0; k < NUM_REFS; k++) begin
                r_cand[k] <= n_sum[k];
            end
        end
    end

    // pairwise minimum, earlier reference wins only when strictly smaller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_pair <= 1'b0;
        end else if (adv) begin
            r_v_pair <= r_v_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_cand[0] < r_cand[1]) begin
                r_pair_id[0]  <= SYM_REF1;
                r_pair_min[0] <= r_cand[0];
            end else begin
                r_pair_id[0]  <= SYM_REF2;
                r_pair_min[0] <= r_cand[1];
            end
            if (r_cand[2] < r_cand[3]) begin
                r_pair_id[1]  <= SYM_REF3;
                r_pair_min[1] <= r_cand[2];
            end else begin
                r_pair_id[1]  <= SYM_REF4;
                r_pair_min[1] <= r_cand[3];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_v_pair) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_v_pair) begin
            r_symbol <= (r_pair_min[0] < r_pair_min[1]) ? r_pair_id[0] : r_pair_id[1];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_symbol = r_symbol;

endmodule

>>> bench/qpsk_symbol_demodulator_tb.sv
`timescale 1ns / 100ps

module qpsk_symbol_demodulator_tb;
    import qpsk_pkg::*;

    localparam int          SETTLE_CYCLES  = 24;
    localparam int          RANDOM_SAMPLES = 850;
    localparam int          QUIET_FROM     = 720;
    localparam longint      TIMEOUT_NS     = 64'd10_000_000;

    // register indexes the block does not decode
    localparam t_cfg_index  CFG_SPARE_A = 2'd2;
    localparam t_cfg_index  CFG_SPARE_B = 2'd3;

    // q30 coefficients of the odd sine polynomial, x^9 term first
    localparam longint      SIN_C9 = 64'sd172272;
    localparam longint      SIN_C7 = -64'sd5026995;
    localparam longint      SIN_C5 = 64'sd85569306;
    localparam longint      SIN_C3 = -64'sd693598669;
    localparam longint      SIN_C1 = 64'sd1686629713;

    // reference phases in eighths of a turn: 3pi/4, pi/4, 5pi/4, 7pi/4
    localparam logic [11:0] REF_OCTANTS = {3'd7, 3'd5, 3'd1, 3'd3};

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind                kind;
        logic signed [31:0]       sample;
        logic                     last;
        bit                       known;
        t_symbol                  symbol;
        t_cfg_index               index;
        logic [CFG_DATA_BITS-1:0] data;
    } t_stim_row;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    t_cfg_index               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    qpsk_in_if #(.SAMPLE_BITS(32)) in_bus ();
    qpsk_out_if                    out_bus ();

    qpsk_symbol_demodulator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_bus),
        .o_out       (out_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    logic [15:0] carrier_phase;
    logic [15:0] phase_step_reg;
    logic [15:0] baud_reload;
    logic [15:0] baud_count;
    logic [63:0] ref_metric [4];

    t_symbol     pending_symbols [$];
    t_stim_row   directed [$];

    bit          override_known;
    t_symbol     override_symbol;
    bit          sender_gaps;
    bit          sink_stalls;
    int          stall_left;

    int          mismatches;
    int          samples_taken;
    int          symbols_checked;
    int          reg_writes;
    int          symbol_hist [4];

    // sine of a 16-bit phase, signed q15
    function automatic longint reference_sine(input logic [15:0] ph);
        longint x, x2, acc, v;
        x = longint'(ph[13:0]) << 2;
        if (ph[14])
            x = 65536 - x;
        x2  = (x * x) >>> 16;
        acc = SIN_C9;
        acc = SIN_C7 + ((acc * x2) >>> 16);
        acc = SIN_C5 + ((acc * x2) >>> 16);
        acc = SIN_C3 + ((acc * x2) >>> 16);
        acc = SIN_C1 + ((acc * x2) >>> 16);
        v   = (acc * x) >>> 16;
        if (v < 0)
            v = 0;
        if (v > (64'sd1 << 30))
            v = 64'sd1 << 30;
        v = (v + (64'sd1 << 14)) >>> 15;
        return ph[15] ? -v : v;
    endfunction

    // accumulate one sample into the four metrics and decide at baud end
    function automatic void demod_sample(input logic signed [31:0] s, input logic last,
                                         output bit fired, output t_symbol sym);
        longint      scaled, d;
        logic [63:0] span;
        logic [64:0] sum;
        logic [15:0] ph;
        t_symbol     w12, w34;
        int          k;
        scaled = longint'(s) * 64'sd32768;
        for (k = 0; k < NUM_REFS; k++) begin
            ph   = carrier_phase + {REF_OCTANTS[3*k +: 3], 13'd0};
            d    = scaled - reference_sine(ph);
            span = (d < 0) ? -d : d;
            sum  = {1'b0, ref_metric[k]} + {1'b0, span};
            ref_metric[k] = sum[64] ? '1 : sum[63:0];
        end
        fired = (baud_count == 16'd0) || last;
        sym   = SYM_REF1;
        if (fired) begin
            w12 = (ref_metric[0] < ref_metric[1]) ? SYM_REF1 : SYM_REF2;
            w34 = (ref_metric[2] < ref_metric[3]) ? SYM_REF3 : SYM_REF4;
            sym = (ref_metric[w12] < ref_metric[w34]) ? w12 : w34;
            for (k = 0; k < NUM_REFS; k++)
                ref_metric[k] = '0;
            baud_count = (baud_reload != 16'd0) ? baud_reload - 16'd1 : 16'd0;
        end else begin
            baud_count = baud_count - 16'd1;
        end
        carrier_phase = carrier_phase - phase_step_reg;
    endfunction

    // mirror the block: register writes, accepted samples, delivered symbols
    always @(posedge clk) begin
        bit      fired;
        t_symbol sym;
        t_symbol want;
        if (!rst_n) begin
            carrier_phase  <= '0;
            phase_step_reg <= '0;
            baud_reload    <= '0;
            baud_count     <= '0;
            for (int k = 0; k < NUM_REFS; k++)
                ref_metric[k] <= '0;
        end else begin
            if (cfg_we) begin
                reg_writes++;
                case (cfg_index)
                    CFG_PHASE_STEP:       phase_step_reg = cfg_data;
                    CFG_SAMPLES_PER_BAUD: begin
                        baud_reload = cfg_data;
                        baud_count  = cfg_data;
                    end
                    default: ;
                endcase
            end
            if (in_bus.valid && in_bus.ready) begin
                samples_taken++;
                demod_sample(in_bus.sample, in_bus.last_sample, fired, sym);
                if (override_known) begin
                    pending_symbols.push_back(override_symbol);
                end else if (fired) begin
                    pending_symbols.push_back(sym);
                end
            end
            if (out_bus.valid && out_bus.ready) begin
                if (pending_symbols.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: symbol %0d arrived with none expected",
                                 $realtime, out_bus.symbol);
                end else begin
                    want = pending_symbols.pop_front();
                    symbols_checked++;
                    symbol_hist[want]++;
                    if (out_bus.symbol !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: symbol mismatch, expected %0d got %0d",
                                     $realtime, want, out_bus.symbol);
                    end
                end
            end
        end
    end

    // output side: ready with random stall bursts
    initial begin
        out_bus.ready = 1'b0;
        stall_left    = 0;
        forever begin
            @(negedge clk);
            if (stall_left != 0) begin
                out_bus.ready <= 1'b0;
                stall_left--;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                out_bus.ready <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // present one item and hold it until taken; called and left at a falling edge
    task automatic push_sample(input logic signed [31:0] s, input logic last);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.sample      <= s;
        in_bus.last_sample <= last;
        do @(posedge clk); while (!in_bus.ready);
        @(negedge clk);
    endtask

    // stop sending and let every expected symbol and the pipeline drain
    task automatic settle();
        in_bus.valid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // mostly small samples near the sine scale, some wide and extreme ones
    function automatic logic signed [31:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 32'($urandom_range(0, 4)) - 32'sd2;
            6, 7:             return {{16{r[15]}}, r[15:0]};
            8:                return r;
            default: begin
                case (r[1:0])
                    2'd0:    return 32'sh7FFF_FFFF;
                    2'd1:    return 32'sh8000_0000;
                    2'd2:    return 32'sh0000_0000;
                    default: return 32'shFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    task automatic add_sample(input logic signed [31:0] s, input logic last,
                              input bit known, input t_symbol sym);
        directed.push_back('{ROW_SAMPLE, s, last, known, sym, CFG_PHASE_STEP, '0});
    endtask

    task automatic add_write(input t_cfg_index idx, input logic [CFG_DATA_BITS-1:0] value);
        directed.push_back('{ROW_WRITE, '0, 1'b0, 1'b0, SYM_REF1, idx, value});
    endtask

    initial begin
        int              random_done;
        int              burst;
        logic [15:0]     new_step;
        logic [15:0]     new_baud;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_PHASE_STEP;
        cfg_data           = '0;
        in_bus.valid       = 1'b0;
        in_bus.sample      = '0;
        in_bus.last_sample = 1'b0;
        override_known     = 1'b0;
        override_symbol    = SYM_REF1;
        sender_gaps        = 1'b1;
        sink_stalls        = 1'b1;
        mismatches         = 0;
        samples_taken      = 0;
        symbols_checked    = 0;
        reg_writes         = 0;
        for (int k = 0; k < 4; k++)
            symbol_hist[k] = 0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // after reset: zero phase, zero step, a decision on every sample;
        // the two positive references tie, as do the two negative ones
        add_sample(32'sh0000_0000, 1'b0, 1'b1, SYM_REF4);
        add_sample(32'sh7FFF_FFFF, 1'b0, 1'b1, SYM_REF2);
        add_sample(32'sh8000_0000, 1'b0, 1'b1, SYM_REF4);
        add_sample(32'sh0000_0001, 1'b0, 1'b1, SYM_REF2);
        add_sample(32'shFFFF_FFFF, 1'b0, 1'b1, SYM_REF4);
        add_sample(32'sh0000_0000, 1'b1, 1'b1, SYM_REF4);
        // quarter-turn step, first baud one sample longer, then a forced decision
        add_write(CFG_PHASE_STEP, 16'd16384);
        add_write(CFG_SAMPLES_PER_BAUD, 16'd3);
        add_sample(32'sd1, 1'b0, 1'b0, SYM_REF1);
        add_sample(-32'sd1, 1'b0, 1'b0, SYM_REF1);
        add_sample(32'sd2, 1'b0, 1'b0, SYM_REF1);
        add_sample(32'sd0, 1'b0, 1'b0, SYM_REF1);
        add_sample(32'sh5555_5555, 1'b1, 1'b0, SYM_REF1);
        // one-sample baud
        add_write(CFG_SAMPLES_PER_BAUD, 16'd1);
        add_sample(-32'sd2, 1'b0, 1'b0, SYM_REF1);
        add_sample(32'sd3, 1'b0, 1'b0, SYM_REF1);
        // largest step and baud, writes to undecoded indexes
        add_write(CFG_PHASE_STEP, 16'hFFFF);
        add_write(CFG_SPARE_A, 16'hFFFF);
        add_write(CFG_SPARE_B, 16'h1234);
        add_write(CFG_SAMPLES_PER_BAUD, 16'hFFFF);
        add_sample(32'sd2, 1'b0, 1'b0, SYM_REF1);
        add_sample(-32'sd3, 1'b0, 1'b0, SYM_REF1);
        add_sample(32'shAAAA_AAAA, 1'b0, 1'b0, SYM_REF1);
        add_sample(32'sd0, 1'b1, 1'b0, SYM_REF1);
        add_write(CFG_SAMPLES_PER_BAUD, 16'd0);
        add_sample(32'sd1, 1'b0, 1'b0, SYM_REF1);
        add_sample(-32'sd1, 1'b1, 1'b0, SYM_REF1);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_WRITE) begin
                settle();
                write_reg(directed[i].index, directed[i].data);
            end else begin
                override_known  = directed[i].known;
                override_symbol = directed[i].symbol;
                push_sample(directed[i].sample, directed[i].last);
            end
        end
        override_known = 1'b0;

        // random bursts, most of them under newly written register settings
        random_done = 0;
        while (random_done < RANDOM_SAMPLES) begin
            settle();
            case ($urandom_range(0, 7))
                0:       new_step = 16'd0;
                1:       new_step = 16'hFFFF;
                2:       new_step = 16'd16384;
                default: new_step = 16'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 9))
                0:       new_baud = 16'd0;
                1:       new_baud = 16'd1;
                2:       new_baud = 16'hFFFF;
                3:       new_baud = 16'($urandom_range(13, 65534));
                default: new_baud = 16'($urandom_range(2, 12));
            endcase
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_PHASE_STEP, new_step);
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_SAMPLES_PER_BAUD, new_baud);
            if ($urandom_range(0, 9) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));

            // no idling in the closing stretch
            if (random_done >= QUIET_FROM) begin
                sender_gaps = 1'b0;
                sink_stalls = 1'b0;
            end else begin
                sender_gaps = ($urandom_range(0, 2) != 0);
                sink_stalls = ($urandom_range(0, 2) != 0);
            end

            burst = $urandom_range(20, 80);
            for (int n = 0; n < burst && random_done < RANDOM_SAMPLES; n++) begin
                push_sample(pick_sample(), $urandom_range(0, 15) == 0);
                random_done++;
            end
        end

        settle();
        $display("covered %0d samples and %0d register writes over many step and baud settings",
                 samples_taken, reg_writes);
        $display("checked %0d symbols: ref1 %0d, ref2 %0d, ref3 %0d, ref4 %0d",
                 symbols_checked, symbol_hist[0], symbol_hist[1], symbol_hist[2],
                 symbol_hist[3]);
        if (mismatches == 0) begin
            $display("qpsk_symbol_demodulator_tb: clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("qpsk_symbol_demodulator_tb: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timed out with %0d symbols outstanding", pending_symbols.size());
        $display("qpsk_symbol_demodulator_tb: errors");
        $finish;
    end

endmodule
